>>> rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg - stereo expander downmix shared definitions
// Sample format, gain constants, payload structs and rounding helpers.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SW          = SAMPLE_BITS;
  localparam int TW          = SAMPLE_BITS - 1;      // threshold in sample units
  localparam int REG_W       = 23;
  localparam int RATIO_FRAC  = 20;
  localparam int GAIN_FRAC   = 23;
  localparam int GAIN_W      = 25;
  localparam int PROD_W      = SW + GAIN_W + 1;
  localparam int OFF_W       = TW + REG_W + 2;
  localparam int ACC_W       = SW + REG_W + 4;
  localparam int NUM_W       = TW + RATIO_FRAC;
  localparam int CNT_W       = $clog2(NUM_W + 1);
  localparam int PIPE_DEPTH  = 7;

  localparam logic [REG_W-1:0] RATIO_ONE = REG_W'(1 << RATIO_FRAC);

  localparam logic signed [GAIN_W-1:0] GAIN_M6DB = 25'sd4204263;
  localparam logic signed [GAIN_W-1:0] GAIN_M3DB = 25'sd5938680;
  localparam logic signed [GAIN_W-1:0] GAIN_M2DB = 25'sd6663308;

  localparam logic signed [ACC_W-1:0] ACC_SMAX =
    {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_SMIN =
    {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] EXP_RND = ACC_W'(1 << (RATIO_FRAC - 1));
  localparam logic signed [PROD_W-1:0] GAIN_RND = PROD_W'(1 << (GAIN_FRAC - 1));

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_RATIO     = 1'b1
  } sed_cfg_idx_t;

  typedef enum logic [1:0] {
    SEL_PASS = 2'd0,
    SEL_POS  = 2'd1,
    SEL_NEG  = 2'd2,
    SEL_ZERO = 2'd3
  } sed_sel_t;

  typedef struct packed {
    logic signed [SW-1:0] left_sample;
    logic signed [SW-1:0] right_sample;
  } sed_in_t;

  typedef struct packed {
    logic signed [SW-1:0] out_front_left;
    logic signed [SW-1:0] out_side_a;
    logic signed [SW-1:0] out_centre;
    logic signed [SW-1:0] out_side_b;
    logic signed [SW-1:0] out_front_right;
  } sed_out_t;

  // expander settings shared by both lanes
  typedef struct packed {
    logic                    bypass;
    logic [REG_W-1:0]        ratio;
    logic [TW-1:0]           thr;
    logic [TW-1:0]           zero_pt;
    logic signed [OFF_W-1:0] offset;
  } sed_exp_cfg_t;

  function automatic logic signed [SW-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    if (v > ACC_SMAX) begin
      return {1'b0, {(SW-1){1'b1}}};
    end else if (v < ACC_SMIN) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return v[SW-1:0];
    end
  endfunction

  // round half up on a Q1.23 gain product, then saturate
  function automatic logic signed [SW-1:0] gain_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + GAIN_RND) >>> GAIN_FRAC;
    return sat_acc(ACC_W'(r));
  endfunction

endpackage

>>> rtl/sed_zdiv.sv
// ----------------------------------------------------------------------------
// sed_zdiv - expander zero point
// Restoring divider, one quotient bit per cycle: z = T - T*2^20/R, >= 0.
// ----------------------------------------------------------------------------
module sed_zdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load_i,
  input  logic [sed_pkg::TW-1:0]    thr_i,
  input  logic [sed_pkg::REG_W-1:0] ratio_i,
  output logic                      busy_o,
  output logic [sed_pkg::TW-1:0]    zero_pt_o
);
  import sed_pkg::*;

  logic             run_r, run_nxt;
  logic             fin_r, fin_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [REG_W-1:0] rem_r;
  logic [TW-1:0]    zero_r, zero_nxt;
  logic [REG_W:0]   rem_sh;
  logic [REG_W-1:0] rem_nxt;
  logic             ge;
  logic             last;

  // remainder stays below the ratio, so it fits in REG_W bits
  assign last    = (cnt_r == CNT_W'(1));
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, ratio_i});
  assign rem_nxt = ge ? REG_W'(rem_sh - {1'b0, ratio_i}) : rem_sh[REG_W-1:0];

  always_comb begin
    run_nxt = run_r;
    if (load_i) begin
      run_nxt = 1'b1;
    end else if (run_r && last) begin
      run_nxt = 1'b0;
    end
    fin_nxt = run_r && last && !load_i;
    // quotient at or above T (or zero ratio) clamps the zero point to 0
    if ((ratio_i != '0) && (num_r < NUM_W'(thr_i))) begin
      zero_nxt = thr_i - num_r[TW-1:0];
    end else begin
      zero_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      num_r <= {thr_i, {RATIO_FRAC{1'b0}}};
      rem_r <= '0;
      cnt_r <= CNT_W'(NUM_W);
    end else if (run_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (fin_r) begin
      zero_r <= zero_nxt;
    end
  end

  assign busy_o    = run_r | fin_r;
  assign zero_pt_o = zero_r;

endmodule

>>> rtl/sed_lane.sv
// ----------------------------------------------------------------------------
// sed_lane - one channel lane
// -6 dB scale, hard-knee expander, -2 dB scale; six register stages.
// ----------------------------------------------------------------------------
module sed_lane (
  input  logic                          clk,
  input  logic signed [sed_pkg::SW-1:0] x_i,
  input  sed_pkg::sed_exp_cfg_t         cfg_i,
  output logic signed [sed_pkg::SW-1:0] scaled_o,
  output logic signed [sed_pkg::SW-1:0] expanded_o
);
  import sed_pkg::*;

  logic signed [PROD_W-1:0] p1_r, p1_nxt;
  logic signed [SW-1:0]     a2_r;
  logic signed [ACC_W-1:0]  m3_r, m3_nxt;
  logic signed [SW-1:0]     a3_r;
  sed_sel_t                 sel3_r, sel3_nxt;
  logic signed [SW-1:0]     y4_r, y4_nxt;
  logic signed [PROD_W-1:0] p5_r, p5_nxt;
  logic signed [SW-1:0]     y6_r;

  logic signed [SW:0]       x_w, t_w, z_w;
  logic signed [ACC_W-1:0]  off_w, acc, ysh;

  assign p1_nxt = PROD_W'(x_i) * PROD_W'(GAIN_M6DB);

  // knee regions on the scaled sample
  assign x_w = (SW+1)'(a2_r);
  assign t_w = $signed({2'b00, cfg_i.thr});
  assign z_w = $signed({2'b00, cfg_i.zero_pt});

  always_comb begin
    m3_nxt = ACC_W'($signed({1'b0, cfg_i.ratio})) * ACC_W'(a2_r);
    if (cfg_i.bypass) begin
      sel3_nxt = SEL_PASS;
    end else if ((x_w < t_w) && (x_w > z_w)) begin
      sel3_nxt = SEL_POS;
    end else if (((x_w <= z_w) && (x_w > 0)) || ((x_w >= -z_w) && (x_w < 0))) begin
      sel3_nxt = SEL_ZERO;
    end else if ((x_w > -t_w) && (x_w < -z_w)) begin
      sel3_nxt = SEL_NEG;
    end else begin
      sel3_nxt = SEL_PASS;
    end
  end

  assign off_w = ACC_W'(cfg_i.offset);
  assign acc   = m3_r + ((sel3_r == SEL_NEG) ? -off_w : off_w) + EXP_RND;
  assign ysh   = acc >>> RATIO_FRAC;

  always_comb begin
    case (sel3_r)
      SEL_POS:  y4_nxt = sat_acc(ysh);
      SEL_NEG:  y4_nxt = sat_acc(ysh);
      SEL_ZERO: y4_nxt = '0;
      default:  y4_nxt = a3_r;
    endcase
  end

  assign p5_nxt = PROD_W'(y4_r) * PROD_W'(GAIN_M2DB);

  always_ff @(posedge clk) begin
    p1_r   <= p1_nxt;
    a2_r   <= gain_round(p1_r);
    m3_r   <= m3_nxt;
    a3_r   <= a2_r;
    sel3_r <= sel3_nxt;
    y4_r   <= y4_nxt;
    p5_r   <= p5_nxt;
    y6_r   <= gain_round(p5_r);
  end

  assign scaled_o   = a2_r;
  assign expanded_o = y6_r;

endmodule

>>> rtl/sed_merge.sv
// ----------------------------------------------------------------------------
// sed_merge - downmix merge
// Centre and side values from both lanes, final sums and output register.
// ----------------------------------------------------------------------------
module sed_merge (
  input  logic                          clk,
  input  logic signed [sed_pkg::SW-1:0] left_scaled_i,
  input  logic signed [sed_pkg::SW-1:0] right_scaled_i,
  input  logic signed [sed_pkg::SW-1:0] left_exp_i,
  input  logic signed [sed_pkg::SW-1:0] right_exp_i,
  output sed_pkg::sed_out_t             res_o
);
  import sed_pkg::*;

  logic signed [SW:0]       sum;
  logic signed [PROD_W-1:0] pc3_r, pc3_nxt;
  logic signed [SW-1:0]     c4_r, c5_r, c6_r;
  logic signed [PROD_W-1:0] pb5_r, pb5_nxt;
  logic signed [SW-1:0]     b6_r;
  sed_out_t                 res_r, res_nxt;

  assign sum     = (SW+1)'(left_scaled_i) + (SW+1)'(right_scaled_i);
  assign pc3_nxt = PROD_W'(sum) * PROD_W'(GAIN_M3DB);
  assign pb5_nxt = PROD_W'(c4_r) * PROD_W'(GAIN_M6DB);

  always_comb begin
    res_nxt.out_front_left  = sat_acc(ACC_W'(left_exp_i) + ACC_W'(b6_r));
    res_nxt.out_side_a      = b6_r;
    res_nxt.out_centre      = c6_r;
    res_nxt.out_side_b      = b6_r;
    res_nxt.out_front_right = sat_acc(ACC_W'(right_exp_i) + ACC_W'(b6_r));
  end

  always_ff @(posedge clk) begin
    pc3_r <= pc3_nxt;
    c4_r  <= gain_round(pc3_r);
    pb5_r <= pb5_nxt;
    c5_r  <= c4_r;
    b6_r  <= gain_round(pb5_r);
    c6_r  <= c5_r;
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

>>> rtl/stereo_expander_downmix.sv
// ----------------------------------------------------------------------------
// stereo_expander_downmix - stereo pair to five-channel downmix
// Two expander lanes plus a merge stage, one stereo pair per clock while not busy.
// ----------------------------------------------------------------------------
//  channel | ports                               | handshake
//  --------+-------------------------------------+----------------------------
//  input   | start, busy, in_data                | taken when start && !busy
//  result  | out_valid, out_data                 | one-cycle strobe, no stall
//  config  | cfg_we, cfg_idx, cfg_wdata          | written when cfg_we
//
//  A new request can be taken every cycle while busy is low. After a register
//  write, busy is high until the zero-point divider, which produces one
//  quotient bit per cycle, has updated the zero point.
//  Synchronous reset clears the registers to threshold 0, ratio 1.0 (bypass).
//  The result side cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module stereo_expander_downmix (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  sed_pkg::sed_in_t          in_data,
  output logic                      out_valid,
  output sed_pkg::sed_out_t         out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [sed_pkg::REG_W-1:0] cfg_wdata
);
  import sed_pkg::*;

  logic [REG_W-1:0]        thr_r, thr_nxt;
  logic [REG_W-1:0]        ratio_r, ratio_nxt;
  logic                    load_r;
  logic [PIPE_DEPTH-1:0]   vld_r;
  logic signed [OFF_W-1:0] off_r;
  logic [TW-1:0]           thr_s;
  logic signed [REG_W:0]   ratio_diff;
  logic                    div_busy;
  logic [TW-1:0]           zero_pt;
  logic                    accept;
  sed_exp_cfg_t            exp_cfg;
  logic signed [SW-1:0]    left_scaled, right_scaled, left_exp, right_exp;

  // threshold aligned to the sample scale
  if (TW >= REG_W) begin : g_thr_up
    assign thr_s = TW'(thr_r) << (TW - REG_W);
  end else begin : g_thr_dn
    assign thr_s = TW'(thr_r >> (REG_W - TW));
  end

  always_comb begin
    thr_nxt   = thr_r;
    ratio_nxt = ratio_r;
    if (cfg_we) begin
      case (sed_cfg_idx_t'(cfg_idx))
        CFG_THRESHOLD: thr_nxt   = cfg_wdata;
        CFG_RATIO:     ratio_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;
  assign busy   = load_r | div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      ratio_r <= RATIO_ONE;
      load_r  <= 1'b0;
      vld_r   <= '0;
    end else begin
      thr_r   <= thr_nxt;
      ratio_r <= ratio_nxt;
      load_r  <= cfg_we;
      vld_r   <= {vld_r[PIPE_DEPTH-2:0], accept};
    end
  end

  // knee offset T*(1 - ratio), settles while the divider runs
  assign ratio_diff = $signed({1'b0, RATIO_ONE}) - $signed({1'b0, ratio_r});

  always_ff @(posedge clk) begin
    off_r <= OFF_W'($signed({1'b0, thr_s})) * OFF_W'(ratio_diff);
  end

  sed_zdiv u_zdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (load_r),
    .thr_i     (thr_s),
    .ratio_i   (ratio_r),
    .busy_o    (div_busy),
    .zero_pt_o (zero_pt)
  );

  always_comb begin
    exp_cfg.bypass  = (thr_s == '0) || (ratio_r == RATIO_ONE);
    exp_cfg.ratio   = ratio_r;
    exp_cfg.thr     = thr_s;
    exp_cfg.zero_pt = zero_pt;
    exp_cfg.offset  = off_r;
  end

  sed_lane u_lane_left (
    .clk        (clk),
    .x_i        (in_data.left_sample),
    .cfg_i      (exp_cfg),
    .scaled_o   (left_scaled),
    .expanded_o (left_exp)
  );

  sed_lane u_lane_right (
    .clk        (clk),
    .x_i        (in_data.right_sample),
    .cfg_i      (exp_cfg),
    .scaled_o   (right_scaled),
    .expanded_o (right_exp)
  );

  sed_merge u_merge (
    .clk            (clk),
    .left_scaled_i  (left_scaled),
    .right_scaled_i (right_scaled),
    .left_exp_i     (left_exp),
    .right_exp_i    (right_exp),
    .res_o          (out_data)
  );

  assign out_valid = vld_r[PIPE_DEPTH-1];

endmodule

>>> rtl/sed_chk.sv
// ----------------------------------------------------------------------------
// sed_chk - port-level checks for stereo_expander_downmix
// Latency, busy cause and side-channel copies, bound to the top level.
// ----------------------------------------------------------------------------
module sed_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input sed_pkg::sed_out_t         out_data,
  input logic                      cfg_we
);
  import sed_pkg::*;

  // every request comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_valid)
    else $error("request lost in pipeline");

  // no result without a matching request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rst_n && start && !busy, PIPE_DEPTH))
    else $error("result without request");

  // busy only follows a register write
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(cfg_we))
    else $error("busy without config write");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("config write did not start zero-point update");

  a_side_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_side_a == out_data.out_side_b))
    else $error("side outputs differ");

endmodule

bind stereo_expander_downmix sed_chk u_sed_chk (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - stereo expander downmix self-checking bench
// Drives stereo pairs through the command port across several expander
// settings, predicts each five-channel result and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import sed_pkg::*;

  localparam int  CYCLE_LIMIT = 200000;
  localparam int  PHASES      = 8;
  localparam int  PHASE_ITEMS = 104;
  localparam longint SMAX     = 64'sd8388607;
  localparam longint SMIN     = -64'sd8388608;

  // ---------------------------------------------------------------------------
  class downmix_scoreboard;
    logic [REG_W-1:0] thr_reg;
    logic [REG_W-1:0] ratio_reg;
    sed_out_t         expected_mix[$];
    int               errors;

    function new();
      thr_reg   = '0;
      ratio_reg = RATIO_ONE;
      errors    = 0;
    endfunction

    function longint sat_sample(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
    endfunction

    // Q1.23 gain with round half up; >>> on longint floors
    function longint apply_gain(longint x, longint g);
      return sat_sample((x * g + (64'sd1 <<< 22)) >>> GAIN_FRAC);
    endfunction

    function longint expand_lane(longint x);
      longint t;
      longint r;
      longint z;
      longint off;
      t = longint'(thr_reg);
      r = longint'(ratio_reg);
      z = 0;
      if (t == 0 || r == longint'(RATIO_ONE)) return x;
      if (r != 0) begin
        z = t - ((t <<< RATIO_FRAC) / r);
        if (z < 0) z = 0;
      end
      off = t * (longint'(RATIO_ONE) - r);
      if (x < t && x > z)
        return sat_sample((r * x + off + (64'sd1 <<< 19)) >>> RATIO_FRAC);
      if ((x <= z && x > 0) || (x >= -z && x < 0)) return 0;
      if (x > -t && x < -z)
        return sat_sample((r * x - off + (64'sd1 <<< 19)) >>> RATIO_FRAC);
      return x;
    endfunction

    function sed_out_t predict_mix(sed_in_t d);
      longint   a;
      longint   e;
      longint   c;
      longint   b;
      longint   a2;
      longint   e2;
      sed_out_t r;
      a  = apply_gain(longint'(d.left_sample), longint'(GAIN_M6DB));
      e  = apply_gain(longint'(d.right_sample), longint'(GAIN_M6DB));
      c  = apply_gain(a + e, longint'(GAIN_M3DB));
      a2 = apply_gain(expand_lane(a), longint'(GAIN_M2DB));
      e2 = apply_gain(expand_lane(e), longint'(GAIN_M2DB));
      b  = apply_gain(c, longint'(GAIN_M6DB));
      r.out_front_left  = SW'(sat_sample(a2 + b));
      r.out_side_a      = SW'(b);
      r.out_centre      = SW'(c);
      r.out_side_b      = SW'(b);
      r.out_front_right = SW'(sat_sample(e2 + b));
      return r;
    endfunction

    function void write_reg(sed_cfg_idx_t idx, logic [REG_W-1:0] v);
      if (idx == CFG_THRESHOLD) thr_reg = v;
      else ratio_reg = v;
    endfunction

    function void note_request(sed_in_t d);
      expected_mix.push_back(predict_mix(d));
    endfunction

    function void check_field(string name, logic signed [SW-1:0] want,
                              logic signed [SW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(sed_out_t got);
      sed_out_t want;
      if (expected_mix.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: got %h", $time, got);
        return;
      end
      want = expected_mix.pop_front();
      check_field("out_front_left",  want.out_front_left,  got.out_front_left);
      check_field("out_side_a",      want.out_side_a,      got.out_side_a);
      check_field("out_centre",      want.out_centre,      got.out_centre);
      check_field("out_side_b",      want.out_side_b,      got.out_side_b);
      check_field("out_front_right", want.out_front_right, got.out_front_right);
    endfunction

    function int pending();
      return expected_mix.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  logic             clk;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  sed_in_t          in_data   = '0;
  logic             out_valid;
  sed_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_idx   = 1'b0;
  logic [REG_W-1:0] cfg_wdata = '0;

  downmix_scoreboard sb = new();
  int                idle_pct = 0;
  int                cycles   = 0;

  stereo_expander_downmix i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // requests, register writes and results all sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(sed_cfg_idx_t'(cfg_idx), cfg_wdata);
      if (start && !busy) sb.note_request(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL stereo_expander_downmix");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  task automatic send_pair(logic signed [SW-1:0] left, logic signed [SW-1:0] right);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start                <= 1'b1;
    in_data.left_sample  <= left;
    in_data.right_sample <= right;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every outstanding request has produced its result
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(sed_cfg_idx_t idx, logic [REG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    // divider recomputes the zero point after every write
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [SW-1:0] pick_sample(longint t);
    longint v;
    case ($urandom_range(7))
      0, 1, 2: return SW'($urandom);
      3, 4: v = 2 * t + longint'($urandom_range(4000)) - 2000;   // around the knee
      5:    v = longint'($urandom_range(32'(2 * t)));            // band and dead zone
      6:    v = longint'($urandom_range(255));
      default: return $urandom_range(1) ? SW'(SMAX - $urandom_range(1))
                                        : SW'(SMIN + $urandom_range(1));
    endcase
    if ($urandom_range(1)) v = -v;
    if (v > SMAX) v = SMAX;
    if (v < SMIN) v = SMIN;
    return SW'(v);
  endfunction

  logic [REG_W-1:0]     thr_plan[PHASES]   = '{23'h200000, 23'h7FFFFF, 23'h100000,
                                               23'h300000, 23'h000000, 23'h180000,
                                               23'h000001, 23'h000000};
  logic [REG_W-1:0]     ratio_plan[PHASES] = '{23'd2097152, 23'h7FFFFF, 23'd0,
                                               23'd524288, 23'd3145728, 23'd1048576,
                                               23'd1, 23'd0};
  int                   idle_plan[4]       = '{0, 75, 0, 24};
  logic signed [SW-1:0] knee_vals[8]       = '{24'sh3FFFFF, 24'sh400000, 24'sh400002,
                                               24'sh300000, 24'sh200000, 24'sh1FFFFE,
                                               24'sh100000, 24'sd1};

  initial begin
    thr_plan[PHASES-1]   = REG_W'($urandom);
    ratio_plan[PHASES-1] = REG_W'($urandom);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings leave the expander bypassed
    send_pair(SW'(SMAX), SW'(SMIN));
    send_pair(SW'(SMIN), SW'(SMAX));
    send_pair('0, '0);
    send_pair(SW'(SMAX), SW'(SMAX));
    send_pair(SW'(SMIN), SW'(SMIN));
    drain();

    // knee, band and dead zone at threshold 0.25, ratio 2.0
    write_reg(CFG_THRESHOLD, thr_plan[0]);
    write_reg(CFG_RATIO, ratio_plan[0]);
    foreach (knee_vals[k]) begin
      send_pair(knee_vals[k], -knee_vals[k]);
      send_pair(-knee_vals[k], knee_vals[k]);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_THRESHOLD, thr_plan[p]);
      write_reg(CFG_RATIO, ratio_plan[p]);
      idle_pct = idle_plan[p % 4];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) drain();
        send_pair(pick_sample(longint'(thr_plan[p])), pick_sample(longint'(thr_plan[p])));
      end
    end

    drain();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS stereo_expander_downmix");
    end else begin
      $display("FAIL stereo_expander_downmix");
    end
    $finish;
  end

endmodule
